@@ rtl/istt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package istt_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH = 64;
  localparam int PTR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SERIAL_W    = 32;
  localparam int KIND_W      = 3;
  localparam int ID_W        = 16;
  localparam int MASK_W      = 8;

  // Command codes; the fourth code is unused and returns a zero result
  typedef enum logic [1:0] {
    CMD_ISSUE    = 2'd0,
    CMD_VALIDATE = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_e;

  // Input word
  typedef struct packed {
    logic [1:0]          cmd;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     client_id;
    logic [ID_W-1:0]     surface_id;
    logic [SERIAL_W-1:0] serial_in;
    logic [MASK_W-1:0]   allowed_kinds;
  } req_t;

  // Result word
  typedef struct packed {
    logic [SERIAL_W-1:0] serial_out;
    logic                is_valid;
  } rsp_t;

  // One table record
  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     client;
    logic [ID_W-1:0]     surface;
  } rec_t;

  // Record memory write port
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] addr;
    rec_t             data;
  } mem_wr_t;

  // Compare results for the record under test
  typedef struct packed {
    logic serial_hit;
    logic pass;
    logic surf_hit;
  } match_t;

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(TABLE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Step a ring pointer back with wrap
  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(TABLE_DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/istt_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module istt_mem (
  input  wire                          clk_i,
  input  wire istt_pkg::mem_wr_t       wr_i,
  input  wire [istt_pkg::PTR_W-1:0]    raddr_i,
  output istt_pkg::rec_t               rdata_o
);
  import istt_pkg::*;

  rec_t mem_q [TABLE_DEPTH];
  rec_t rdata_q;

  // Write one record, read one record with registered data
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/istt_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

module istt_match (
  input  wire istt_pkg::rec_t   rec_i,
  input  wire istt_pkg::req_t   req_i,
  output istt_pkg::match_t      match_o
);
  import istt_pkg::*;

  logic kind_ok;
  logic client_ok;
  logic surf_ok;

  // Check the record against the held command word
  assign kind_ok   = req_i.allowed_kinds[rec_i.kind];
  assign client_ok = (req_i.client_id == '0) || (rec_i.client == req_i.client_id);
  assign surf_ok   = (req_i.surface_id == '0) || (rec_i.surface == req_i.surface_id);

  assign match_o.serial_hit = (rec_i.serial == req_i.serial_in);
  assign match_o.pass       = kind_ok && client_ok && surf_ok;
  assign match_o.surf_hit   = (rec_i.surface == req_i.surface_id);

endmodule

`default_nettype wire

@@ rtl/istt_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module istt_seq (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire istt_pkg::req_t          req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output istt_pkg::rsp_t               rsp_o,
  output istt_pkg::req_t               cur_req_o,
  output istt_pkg::mem_wr_t            mem_wr_o,
  output logic [istt_pkg::PTR_W-1:0]   mem_raddr_o,
  input  wire istt_pkg::rec_t          mem_rdata_i,
  input  wire istt_pkg::match_t        match_i
);
  import istt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CLEAR = 3'b100
  } state_e;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic [SERIAL_W-1:0] next_q, next_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PTR_W-1:0]    rptr_q, rptr_d;
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [CNT_W-1:0]    left_q, left_d;
  logic [CNT_W-1:0]    kept_q, kept_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;
  logic [SERIAL_W-1:0] issue_serial;
  logic                accept;

  assign accept = start_i && (state_q == S_IDLE);

  // Skip serial zero on wrap
  assign issue_serial = (next_q == '0) ? SERIAL_W'(1) : next_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    next_d   = next_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    rptr_d   = rptr_q;
    wptr_d   = wptr_q;
    left_d   = left_q;
    kept_d   = kept_q;
    pend_d   = 1'b0;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    mem_wr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          case (req_i.cmd)
            CMD_ISSUE: begin
              // Append at the tail, drop the oldest when full
              next_d             = issue_serial + SERIAL_W'(1);
              mem_wr_o.we        = 1'b1;
              mem_wr_o.addr      = tail_q;
              mem_wr_o.data      = '{serial:  issue_serial,
                                     kind:    req_i.kind,
                                     client:  req_i.client_id,
                                     surface: req_i.surface_id};
              tail_d             = ptr_inc(tail_q);
              if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
                head_d = ptr_inc(head_q);
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
              done_d = 1'b1;
              rsp_d  = '{serial_out: issue_serial, is_valid: 1'b0};
            end
            CMD_VALIDATE: begin
              if ((req_i.serial_in == '0) || (req_i.allowed_kinds == '0) ||
                  (cnt_q == '0)) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end else begin
                state_d = S_SCAN;
                rptr_d  = ptr_dec(tail_q);
                left_d  = cnt_q;
              end
            end
            CMD_CLEAR: begin
              if ((req_i.surface_id == '0) || (cnt_q == '0)) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end else begin
                state_d = S_CLEAR;
                rptr_d  = head_q;
                wptr_d  = head_q;
                left_d  = cnt_q;
                kept_d  = '0;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Walk newest to oldest; the first serial hit decides
        if (pend_q && match_i.serial_hit) begin
          done_d  = 1'b1;
          rsp_d   = '{serial_out: '0, is_valid: match_i.pass};
          state_d = S_IDLE;
        end else if (left_q != '0) begin
          rptr_d = ptr_dec(rptr_q);
          left_d = left_q - CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_CLEAR: begin
        // Compact kept records toward the head in age order
        if (pend_q && !match_i.surf_hit) begin
          mem_wr_o.we   = 1'b1;
          mem_wr_o.addr = wptr_q;
          mem_wr_o.data = mem_rdata_i;
          wptr_d        = ptr_inc(wptr_q);
          kept_d        = kept_q + CNT_W'(1);
        end
        if (left_q != '0) begin
          rptr_d = ptr_inc(rptr_q);
          left_d = left_q - CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          cnt_d   = kept_d;
          tail_d  = wptr_d;
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      next_q  <= SERIAL_W'(1);
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rptr_q <= rptr_d;
    wptr_q <= wptr_d;
    left_q <= left_d;
    kept_q <= kept_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cur_req_o   = req_q;
  assign mem_raddr_o = rptr_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_issue_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.cmd == CMD_ISSUE)) |=> (done_q && (rsp_q.serial_out != '0)))
    else $error("issue did not return a nonzero serial");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q != S_IDLE) && (state_q == S_IDLE)) |-> done_q)
    else $error("command finished without a result word");

  a_clear_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (cnt_q <= $past(cnt_q)))
    else $error("clear grew the table");
`endif

endmodule

`default_nettype wire

@@ rtl/input_serial_tracking_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Age-ordered table of issued input serials, kept as a ring in one record memory
// with a single read port. A word is taken when start is high and busy is low;
// its result appears on rsp_o with done_o high for exactly one cycle, and the
// receiver cannot stall it. Issue, unused commands, and validate or clear that
// need no lookup (serial 0, empty mask, surface 0, empty table) keep busy low and
// give the result on the cycle after acceptance, so one may follow every cycle.
// Validate stays busy while it walks the N records held (N up to 64), stopping
// at the newest record with the serial; clear stays busy until it has walked all
// N records. Both walk the memory one record per cycle through its read port,
// and clear writes kept records back through the write port.
module input_serial_tracking_table (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  wire istt_pkg::req_t  req_i,
  output logic                 busy,
  output logic                 done_o,
  output istt_pkg::rsp_t       rsp_o
);
  import istt_pkg::*;

  req_t             cur_req;
  mem_wr_t          mem_wr;
  logic [PTR_W-1:0] mem_raddr;
  rec_t             mem_rdata;
  match_t           match;

  istt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cur_req_o   (cur_req),
    .mem_wr_o    (mem_wr),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .match_i     (match)
  );

  istt_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  istt_match u_match (
    .rec_i   (mem_rdata),
    .req_i   (cur_req),
    .match_o (match)
  );

endmodule

`default_nettype wire
